/* design/rcp_pkg.sv */
// shared constants, types and operand tables of the rational cubic projection unit
`timescale 1ns / 1ps
package rcp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 32;
  localparam int COORD_FRAC  = COORD_WIDTH - 2;
  localparam int COEF_FRAC   = COEF_WIDTH - 5;
  localparam int MON_FRAC    = (COORD_FRAC < 60 - COEF_WIDTH) ? COORD_FRAC : 60 - COEF_WIDTH;
  localparam int COORD_SHIFT = COORD_FRAC - MON_FRAC;
  localparam int MONO_WIDTH  = MON_FRAC + 6;
  localparam int TERM_WIDTH  = COEF_WIDTH + 6;
  localparam int POLY_WIDTH  = COEF_WIDTH + 11;

  localparam int NUM_MONO    = 20;
  localparam int NUM_POLY    = 4;
  localparam int NUM_COEF    = 80;
  localparam int NUM_SQ      = 6;
  localparam int NUM_OPS     = NUM_SQ + NUM_MONO;
  localparam int INDEX_WIDTH = 7;
  localparam int ROW_WIDTH   = $clog2(NUM_MONO);
  localparam int LANE_WIDTH  = $clog2(NUM_POLY);
  localparam int OP_WIDTH    = $clog2(NUM_OPS);
  localparam int SQ_WIDTH    = $clog2(NUM_SQ);
  localparam int CNT_WIDTH   = $clog2(COEF_WIDTH);
  localparam int ROW_BITS    = NUM_POLY * COEF_WIDTH;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    OPND_X, OPND_Y, OPND_Z, OPND_XX, OPND_XY, OPND_XZ, OPND_YY, OPND_YZ, OPND_ZZ, OPND_ONE
  } opnd_t;

  // squares first, then the twenty monomials in slot order
  localparam opnd_t OP_A [NUM_OPS] = '{
    OPND_X, OPND_X, OPND_X, OPND_Y, OPND_Y, OPND_Z,
    OPND_X, OPND_X, OPND_X, OPND_XX, OPND_X, OPND_X, OPND_XY, OPND_X, OPND_XZ, OPND_X,
    OPND_Y, OPND_Y, OPND_YY, OPND_Y, OPND_YZ, OPND_Y, OPND_Z, OPND_ZZ, OPND_Z, OPND_ONE
  };
  localparam opnd_t OP_B [NUM_OPS] = '{
    OPND_X, OPND_Y, OPND_Z, OPND_Y, OPND_Z, OPND_Z,
    OPND_XX, OPND_XY, OPND_XZ, OPND_ONE, OPND_YY, OPND_YZ, OPND_ONE, OPND_ZZ, OPND_ONE,
    OPND_ONE, OPND_YY, OPND_YZ, OPND_ONE, OPND_ZZ, OPND_ONE, OPND_ONE, OPND_ZZ, OPND_ONE,
    OPND_ONE, OPND_ONE
  };

  typedef struct packed {
    logic                          cmd;
    logic [INDEX_WIDTH-1:0]        coef_index;
    logic signed [COEF_WIDTH-1:0]  coef_value;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
    logic signed [COEF_WIDTH-1:0]  obs_u;
    logic signed [COEF_WIDTH-1:0]  obs_v;
  } rcp_req_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] proj_u;
    logic signed [COEF_WIDTH-1:0] proj_v;
    logic signed [COEF_WIDTH-1:0] resid_u;
    logic signed [COEF_WIDTH-1:0] resid_v;
    logic [1:0]                   div_fault;
  } rcp_rsp_t;

  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic signed [MONO_WIDTH-1:0] val;
  } mono_t;

  typedef struct packed {
    logic                         zero;
    logic signed [COEF_WIDTH-1:0] quot;
  } div_res_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WR_RD = 7'b0000100,
    S_WR_WR = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_CHECK = 4'b0010,
    DV_ITER  = 4'b0100,
    DV_DONE  = 4'b1000
  } div_state_t;

endpackage

/* design/rcp_ram.sv */
// generic memory with one write port and one registered read port
`timescale 1ns / 1ps
module rcp_ram import rcp_pkg::*; #(
  parameter int WIDTH = ROW_BITS,
  parameter int DEPTH = NUM_MONO
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/rcp_mono.sv */
// monomial sequencer: squares then the twenty monomials through one shared multiplier
`timescale 1ns / 1ps
module rcp_mono import rcp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic [ROW_WIDTH-1:0]          rd_row,
  output mono_t                         mono
);

  localparam int PW = 2 * MONO_WIDTH;
  localparam logic signed [COORD_WIDTH:0] CRND =
    (COORD_SHIFT == 0) ? '0 : ((COORD_WIDTH+1)'(1) << (COORD_SHIFT - 1));
  localparam logic signed [PW-1:0] PHALF = PW'(1) << (MON_FRAC - 1);
  localparam logic signed [MONO_WIDTH-1:0] MONO_ONE = MONO_WIDTH'(1) << MON_FRAC;

  logic signed [MONO_WIDTH-1:0] x, y, z;
  logic signed [MONO_WIDTH-1:0] sq [NUM_SQ];
  logic                         run;
  logic [OP_WIDTH-1:0]          op;
  logic signed [PW-1:0]         prod;
  logic                         prod_valid;
  logic [OP_WIDTH-1:0]          prod_op;
  logic signed [MONO_WIDTH-1:0] opa, opb, rnd;
  logic signed [PW-1:0]         psum;

  function automatic logic signed [MONO_WIDTH-1:0] round_coord(
    input logic signed [COORD_WIDTH-1:0] c
  );
    logic signed [COORD_WIDTH:0] t;
    t = {c[COORD_WIDTH-1], c} + CRND;
    return MONO_WIDTH'(t >>> COORD_SHIFT);
  endfunction

  function automatic logic signed [MONO_WIDTH-1:0] pick(input opnd_t o);
    logic signed [MONO_WIDTH-1:0] v;
    case (o)
      OPND_X:  v = x;
      OPND_Y:  v = y;
      OPND_Z:  v = z;
      OPND_XX: v = sq[0];
      OPND_XY: v = sq[1];
      OPND_XZ: v = sq[2];
      OPND_YY: v = sq[3];
      OPND_YZ: v = sq[4];
      OPND_ZZ: v = sq[5];
      default: v = MONO_ONE;
    endcase
    return v;
  endfunction

  always_comb begin
    opa    = pick(OP_A[op]);
    opb    = pick(OP_B[op]);
    psum   = prod + PHALF;
    rnd    = MONO_WIDTH'(psum >>> MON_FRAC);
    rd_row = ROW_WIDTH'(prod_op - OP_WIDTH'(NUM_SQ));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      prod_valid <= 1'b0;
      mono.valid <= 1'b0;
      op         <= '0;
    end else begin
      if (start) begin
        run <= 1'b1;
        op  <= '0;
      end else if (run) begin
        op <= op + 1'b1;
        if (op == OP_WIDTH'(NUM_OPS - 1)) begin
          run <= 1'b0;
        end
      end
      prod_valid <= run;
      mono.valid <= prod_valid && (prod_op >= OP_WIDTH'(NUM_SQ));
    end
    mono.last <= (prod_op == OP_WIDTH'(NUM_OPS - 1));
    mono.val  <= rnd;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= round_coord(x_coord);
      y <= round_coord(y_coord);
      z <= round_coord(z_coord);
    end
    prod    <= opa * opb;
    prod_op <= op;
    if (prod_valid && (prod_op < OP_WIDTH'(NUM_SQ))) begin
      sq[prod_op[SQ_WIDTH-1:0]] <= rnd;
    end
  end

endmodule

/* design/rcp_mac.sv */
// four multiply-accumulate lanes, one per polynomial, fed a coefficient row per monomial
`timescale 1ns / 1ps
module rcp_mac import rcp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  mono_t                        mono,
  input  logic [ROW_BITS-1:0]          row_data,
  output logic signed [POLY_WIDTH-1:0] poly [NUM_POLY],
  output logic                         done
);

  localparam int TP = COEF_WIDTH + MONO_WIDTH;
  localparam logic signed [TP-1:0] THALF = TP'(1) << (MON_FRAC - 1);

  logic prod_valid, prod_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= mono.valid;
      prod_last  <= mono.valid && mono.last;
      done       <= prod_valid && prod_last;
    end
  end

  for (genvar j = 0; j < NUM_POLY; j++) begin : g_lane
    logic signed [TP-1:0]         tprod, tsum;
    logic signed [TERM_WIDTH-1:0] term;

    always_comb begin
      tsum = tprod + THALF;
      term = TERM_WIDTH'(tsum >>> MON_FRAC);
    end

    always_ff @(posedge clk) begin
      tprod <= $signed(row_data[j*COEF_WIDTH +: COEF_WIDTH]) * mono.val;
      if (start) begin
        poly[j] <= '0;
      end else if (prod_valid) begin
        poly[j] <= poly[j] + POLY_WIDTH'(term);
      end
    end
  end

endmodule

/* design/rcp_div.sv */
// restoring divider, one quotient bit a cycle, with overflow and zero checks
`timescale 1ns / 1ps
module rcp_div import rcp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [POLY_WIDTH-1:0] num,
  input  logic signed [POLY_WIDTH-1:0] den,
  output logic                         done,
  output div_res_t                     res
);

  div_state_t              state;
  logic                    neg, zero, num_neg, num_nz, big;
  logic [POLY_WIDTH-1:0]   n_abs, d_abs;
  logic [POLY_WIDTH:0]     rem, trial;
  logic [COEF_WIDTH-1:0]   shreg, q;
  logic [CNT_WIDTH-1:0]    cnt;

  always_comb begin
    trial = {rem[POLY_WIDTH-1:0], shreg[COEF_WIDTH-1]};
    done  = (state == DV_DONE);
    res.zero = zero;
    if (zero) begin
      res.quot = !num_nz ? '0 : (num_neg ? COEF_MIN : COEF_MAX);
    end else if (neg) begin
      res.quot = (big || (q[COEF_WIDTH-1] && |q[COEF_WIDTH-2:0])) ? COEF_MIN : -q;
    end else begin
      res.quot = (big || q[COEF_WIDTH-1]) ? COEF_MAX : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else if (start) begin
      state <= DV_CHECK;
    end else begin
      unique case (state)
        DV_IDLE:  state <= DV_IDLE;
        DV_CHECK: state <= DV_ITER;
        DV_ITER: begin
          if (cnt == CNT_WIDTH'(COEF_WIDTH - 1)) begin
            state <= DV_DONE;
          end
        end
        DV_DONE:  state <= DV_DONE;
        default:  state <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[POLY_WIDTH-1] ^ den[POLY_WIDTH-1];
      num_neg <= num[POLY_WIDTH-1];
      num_nz  <= (num != '0);
      zero    <= (den == '0);
      n_abs   <= num[POLY_WIDTH-1] ? -num : num;
      d_abs   <= den[POLY_WIDTH-1] ? -den : den;
    end else if (state == DV_CHECK) begin
      // quotient of n * 2^frac / d reaches 2^width exactly when n >= 32 * d
      big   <= {5'b0, n_abs} >= {d_abs, 5'b0};
      rem   <= (POLY_WIDTH+1)'(n_abs >> 5);
      shreg <= {n_abs[4:0], {COEF_FRAC{1'b0}}};
      q     <= '0;
      cnt   <= '0;
    end else if (state == DV_ITER) begin
      if (trial >= {1'b0, d_abs}) begin
        rem <= trial - {1'b0, d_abs};
        q   <= {q[COEF_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[COEF_WIDTH-2:0], 1'b0};
      end
      shreg <= shreg << 1;
      cnt   <= cnt + 1'b1;
    end
  end

endmodule

/* design/rational_cubic_projection_unit.sv */
// top level: coefficient memory, control, monomial sequencer, mac lanes, dividers, output register
//
//   channel | handshake            | payload   | carries
//   req     | req_valid/req_ready  | rcp_req_t | coefficient write or point to project
//   rsp     | rsp_valid/rsp_ready  | rcp_rsp_t | projection, residuals, fault bits
//
// a projection runs from transfer to result in this order:
// 26 shared-multiplier steps, the mac lanes, then COEF_WIDTH divider iterations
// a coefficient write is a read-modify-write of one memory row
// after reset a clearing pass over all 20 rows zeroes the memory, req_ready stays low
// a result waits in the output register; the next request is taken while it waits
`timescale 1ns / 1ps
module rational_cubic_projection_unit import rcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  rcp_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rcp_rsp_t rsp
);

  state_t                       state;
  logic [ROW_WIDTH-1:0]         clr_row, wr_row, dec_row, mono_row;
  logic [LANE_WIDTH-1:0]        wr_lane, dec_lane;
  logic signed [COEF_WIDTH-1:0] wr_value, obs_u, obs_v;
  logic                         ram_we;
  logic [ROW_WIDTH-1:0]         ram_waddr, ram_raddr;
  logic [ROW_BITS-1:0]          ram_wdata, ram_rdata, merged;
  logic                         take, proj_start, mac_done, div_start, load;
  mono_t                        mono;
  logic signed [POLY_WIDTH-1:0] poly [NUM_POLY];
  logic                         du_done, dv_done;
  div_res_t                     du_res, dv_res;

  function automatic logic signed [COEF_WIDTH-1:0] sat_sub(
    input logic signed [COEF_WIDTH-1:0] a,
    input logic signed [COEF_WIDTH-1:0] b
  );
    logic signed [COEF_WIDTH:0] d;
    d = {a[COEF_WIDTH-1], a} - {b[COEF_WIDTH-1], b};
    if (d[COEF_WIDTH] != d[COEF_WIDTH-1]) begin
      return d[COEF_WIDTH] ? COEF_MIN : COEF_MAX;
    end
    return d[COEF_WIDTH-1:0];
  endfunction

  always_comb begin
    if (req.coef_index >= INDEX_WIDTH'(3 * NUM_MONO)) begin
      dec_lane = LANE_WIDTH'(3);
      dec_row  = ROW_WIDTH'(req.coef_index - INDEX_WIDTH'(3 * NUM_MONO));
    end else if (req.coef_index >= INDEX_WIDTH'(2 * NUM_MONO)) begin
      dec_lane = LANE_WIDTH'(2);
      dec_row  = ROW_WIDTH'(req.coef_index - INDEX_WIDTH'(2 * NUM_MONO));
    end else if (req.coef_index >= INDEX_WIDTH'(NUM_MONO)) begin
      dec_lane = LANE_WIDTH'(1);
      dec_row  = ROW_WIDTH'(req.coef_index - INDEX_WIDTH'(NUM_MONO));
    end else begin
      dec_lane = '0;
      dec_row  = ROW_WIDTH'(req.coef_index);
    end
  end

  always_comb begin
    req_ready  = (state == S_IDLE);
    take       = req_valid && req_ready;
    proj_start = take && (req.cmd == CMD_PROJECT);
    div_start  = (state == S_EVAL) && mac_done;
    load       = (state == S_FIN) && (!rsp_valid || rsp_ready);
    merged     = ram_rdata;
    merged[wr_lane*COEF_WIDTH +: COEF_WIDTH] = wr_value;
    ram_we     = (state == S_CLEAR) || (state == S_WR_WR);
    ram_waddr  = (state == S_CLEAR) ? clr_row : wr_row;
    ram_wdata  = (state == S_CLEAR) ? '0 : merged;
    ram_raddr  = (state == S_WR_RD) ? wr_row : mono_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_WIDTH'(NUM_MONO - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (proj_start) begin
            state <= S_EVAL;
          end else if (take && (req.coef_index < INDEX_WIDTH'(NUM_COEF))) begin
            state <= S_WR_RD;
          end
        end
        S_WR_RD: state <= S_WR_WR;
        S_WR_WR: state <= S_IDLE;
        S_EVAL: begin
          if (mac_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (du_done && dv_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wr_row   <= dec_row;
      wr_lane  <= dec_lane;
      wr_value <= req.coef_value;
      obs_u    <= req.obs_u;
      obs_v    <= req.obs_v;
    end
    if (load) begin
      rsp.proj_u    <= du_res.quot;
      rsp.proj_v    <= dv_res.quot;
      rsp.resid_u   <= sat_sub(du_res.quot, obs_u);
      rsp.resid_v   <= sat_sub(dv_res.quot, obs_v);
      rsp.div_fault <= {dv_res.zero, du_res.zero};
    end
  end

  rcp_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(NUM_MONO)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcp_mono u_mono (
    .clk     (clk),
    .rst     (rst),
    .start   (proj_start),
    .x_coord (req.x_coord),
    .y_coord (req.y_coord),
    .z_coord (req.z_coord),
    .rd_row  (mono_row),
    .mono    (mono)
  );

  rcp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .start    (proj_start),
    .mono     (mono),
    .row_data (ram_rdata),
    .poly     (poly),
    .done     (mac_done)
  );

  rcp_div u_div_u (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (poly[0]),
    .den   (poly[1]),
    .done  (du_done),
    .res   (du_res)
  );

  rcp_div u_div_v (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (poly[2]),
    .den   (poly[3]),
    .done  (dv_done),
    .res   (dv_res)
  );

endmodule

/* design/rcp_checker.sv */
// port-level checks of the rational cubic projection unit, bound to the top level
`timescale 1ns / 1ps
module rcp_checker import rcp_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input rcp_req_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input rcp_rsp_t rsp
);

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // memory clearing pass blocks requests right after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  // a projection occupies the block after its transfer
  a_proj_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.cmd == CMD_PROJECT) |=> !req_ready)
    else $error("request taken while projection in flight");

  // zero u denominator gives a saturated or zero ratio
  a_fault_u: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_fault[0] |->
      (rsp.proj_u == COEF_MAX) || (rsp.proj_u == COEF_MIN) || (rsp.proj_u == '0))
    else $error("u fault with unsaturated ratio");

  a_fault_v: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_fault[1] |->
      (rsp.proj_v == COEF_MAX) || (rsp.proj_v == COEF_MIN) || (rsp.proj_v == '0))
    else $error("v fault with unsaturated ratio");

endmodule

bind rational_cubic_projection_unit rcp_checker u_rcp_checker (.*);
